@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define MTDR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mtdr assertion failed");

// check on every rising edge, reset included
`define MTDR_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mtdr reset assertion failed");

`endif

@@ hw/rtl/mtdr_pkg.sv @@
// ----------------------------------------------------------------------------
// mtdr_pkg
// shared constants, tap tables and types of the multi-tap delay block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtdr_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int SAMPLE_W   = 16;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int NUM_TAPS   = 5;
    localparam int TAP_W      = 3;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 16;

    // shared multiplier: signed 20 x signed 17
    localparam int MUL_A_W    = 20;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int HI_W       = MUL_A_W - 1;

    // 1/4.95 in q0.16
    localparam int SCALE_Q16  = 13240;

    // sequencer steps
    localparam int STEP_W     = 4;
    localparam int LAST_TAP   = NUM_TAPS - 1;
    localparam int LO_STEP    = NUM_TAPS + 1;
    localparam int HI_STEP    = NUM_TAPS + 2;
    localparam int LAST_STEP  = NUM_TAPS + 3;

    typedef struct packed {
        logic load;
        logic add;
        logic rnd;
    } mac_ctl_t;

    // tap gains, unsigned q0.16
    function automatic logic [GAIN_W-1:0] tap_gain(input logic [TAP_W-1:0] k);
        logic [GAIN_W-1:0] g;
        case (k)
            3'd0:    g = GAIN_W'(54395);
            3'd1:    g = GAIN_W'(53084);
            3'd2:    g = GAIN_W'(51773);
            3'd3:    g = GAIN_W'(50463);
            3'd4:    g = GAIN_W'(49152);
            default: g = '0;
        endcase
        return g;
    endfunction

    // tap delays in samples
    function automatic logic [ADDR_W-1:0] tap_offset(input logic [TAP_W-1:0] k);
        logic [ADDR_W-1:0] o;
        case (k)
            3'd0:    o = ADDR_W'(1600);
            3'd1:    o = ADDR_W'(1792);
            3'd2:    o = ADDR_W'(1952);
            3'd3:    o = ADDR_W'(2176);
            3'd4:    o = ADDR_W'(2304);
            default: o = '0;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/multi_tap_delay_reverb.sv @@
// ----------------------------------------------------------------------------
// multi_tap_delay_reverb
// five-tap delay echo over a circular sample store, one shared multiplier
// ----------------------------------------------------------------------------
// path: bypass beats (disabled or first pass) pass the result reg, then the
//   output reg; echo beats run the sequencer steps before the result reg
// flow: a new beat is taken only after the last one reaches the output reg;
//   echo beats take five store reads and seven passes through the one multiplier
// reset: async active low, clears enable, write index, fill flag, sequencer
//   and output valid; the store itself is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module multi_tap_delay_reverb (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // config
    input  wire logic                          enable_we,
    input  wire logic                          enable_wdata,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [mtdr_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [15:0] sample_in
    // output stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [mtdr_pkg::SAMPLE_W-1:0] m_axis_tdata   // [15:0] sample_out
);

    localparam int SW = mtdr_pkg::SAMPLE_W;
    localparam int AW = mtdr_pkg::ADDR_W;
    localparam int PW = mtdr_pkg::PROD_W;
    localparam int RW = PW - mtdr_pkg::FRAC_W;

    localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(mtdr_pkg::RING_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(mtdr_pkg::RING_DEPTH - 1);
    localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (SW - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_LO = -RW'(64'sd1 <<< (SW - 1));

    localparam logic [mtdr_pkg::STEP_W-1:0] ST_LAST_TAP =
        mtdr_pkg::STEP_W'(mtdr_pkg::LAST_TAP);
    localparam logic [mtdr_pkg::STEP_W-1:0] ST_LO   = mtdr_pkg::STEP_W'(mtdr_pkg::LO_STEP);
    localparam logic [mtdr_pkg::STEP_W-1:0] ST_HI   = mtdr_pkg::STEP_W'(mtdr_pkg::HI_STEP);
    localparam logic [mtdr_pkg::STEP_W-1:0] ST_LAST = mtdr_pkg::STEP_W'(mtdr_pkg::LAST_STEP);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // control registers
    state_t                        state_reg, state_next;
    logic [mtdr_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                          enable_reg, enable_next;
    logic                          filled_reg, filled_next;
    logic [AW-1:0]                 wr_idx_reg, wr_idx_next;
    logic                          m_tvalid_reg, m_tvalid_next;

    // payload registers
    logic [SW-1:0]                 result_reg, result_next;
    logic [SW-1:0]                 m_tdata_reg, m_tdata_next;

    logic                          in_beat;
    logic                          advance;
    logic [AW-1:0]                 wr_idx_inc;

    // tap address generation
    logic [mtdr_pkg::TAP_W-1:0]    tap_sel;
    logic [mtdr_pkg::TAP_W-1:0]    gain_sel;
    logic [AW-1:0]                 tap_off;
    logic [AW-1:0]                 tap_addr;
    logic [AW:0]                   wrap_addr;
    logic [SW-1:0]                 tap_data;

    // shared multiply-accumulate
    mtdr_pkg::mac_ctl_t            mac_ctl;
    logic signed [mtdr_pkg::MUL_A_W-1:0] mac_a;
    logic signed [mtdr_pkg::MUL_B_W-1:0] mac_b;
    logic signed [PW-1:0]          mac_init;
    logic signed [PW-1:0]          mac_prod;
    logic signed [PW-1:0]          mac_acc;
    logic signed [PW-1:0]          scaled;
    logic signed [RW-1:0]          rounded;
    logic [SW-1:0]                 sat_val;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // tap 0 is read on the accept cycle, taps 1..4 on the first run steps
    assign tap_sel   = (state_reg == ST_IDLE) ? '0
                     : mtdr_pkg::TAP_W'(step_reg + 1'b1);
    assign gain_sel  = mtdr_pkg::TAP_W'(step_reg);
    assign tap_off   = mtdr_pkg::tap_offset(tap_sel);
    assign wrap_addr = {1'b0, wr_idx_reg} + DEPTH_X - {1'b0, tap_off};
    assign tap_addr  = (wr_idx_reg >= tap_off) ? (wr_idx_reg - tap_off)
                     : wrap_addr[AW-1:0];

    assign wr_idx_inc = (wr_idx_reg == LAST_IDX) ? '0 : (wr_idx_reg + 1'b1);

    // current sample in q16 seeds the accumulator
    assign mac_init = PW'($signed(s_axis_tdata)) <<< mtdr_pkg::FRAC_W;

    mtdr_ring_ram u_ram (
        .clk   (clk),
        .we    (in_beat && enable_reg),
        .waddr (wr_idx_reg),
        .wdata (s_axis_tdata),
        .raddr (tap_addr),
        .rdata (tap_data)
    );

    mtdr_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (mac_a),
        .op_b (mac_b),
        .init (mac_init),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    // final q16 -> integer: high partial product plus rounded low part
    assign scaled  = mac_prod + mac_acc;
    assign rounded = RW'(scaled >>> mtdr_pkg::FRAC_W);
    assign sat_val = (rounded > SAT_HI) ? SW'(SAT_HI)
                   : (rounded < SAT_LO) ? SW'(SAT_LO)
                   : rounded[SW-1:0];

    // operand select for the shared multiplier
    always_comb
    begin
        mac_ctl.load = in_beat;
        mac_ctl.add  = 1'b0;
        mac_ctl.rnd  = 1'b0;
        mac_a        = '0;
        mac_b        = '0;
        if (state_reg == ST_RUN)
        begin
            if (step_reg <= ST_LAST_TAP)
            begin
                // delayed sample times its tap gain
                mac_a = mtdr_pkg::MUL_A_W'($signed(tap_data));
                mac_b = $signed({1'b0, mtdr_pkg::tap_gain(gain_sel)});
            end
            else if (step_reg == ST_LO)
            begin
                // low 16 bits of the sum times the output scale
                mac_a = $signed({{(mtdr_pkg::MUL_A_W - mtdr_pkg::FRAC_W){1'b0}},
                                 mac_acc[mtdr_pkg::FRAC_W-1:0]});
                mac_b = mtdr_pkg::MUL_B_W'(mtdr_pkg::SCALE_Q16);
            end
            else if (step_reg == ST_HI)
            begin
                // upper bits of the sum times the output scale
                mac_a = $signed({mac_acc[mtdr_pkg::FRAC_W+mtdr_pkg::HI_W-1],
                                 mac_acc[mtdr_pkg::FRAC_W+mtdr_pkg::HI_W-1:
                                         mtdr_pkg::FRAC_W]});
                mac_b = mtdr_pkg::MUL_B_W'(mtdr_pkg::SCALE_Q16);
            end
            // products of the tap steps are added in the step after they are issued
            mac_ctl.add = (step_reg >= 4'd1) && (step_reg <= ST_LAST_TAP + 1'b1);
            mac_ctl.rnd = (step_reg == ST_HI);
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        enable_next   = enable_we ? enable_wdata : enable_reg;
        filled_next   = filled_reg;
        wr_idx_next   = wr_idx_reg;
        result_next   = result_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        advance       = 1'b0;

        if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    step_next = '0;
                    if (enable_reg && filled_reg)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        // bypass: disabled, or store still on its first pass
                        result_next = s_axis_tdata;
                        advance     = enable_reg;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == ST_LAST)
                begin
                    result_next = sat_val;
                    advance     = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // output reg frees up when the previous beat is taken
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = result_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance)
        begin
            wr_idx_next = wr_idx_inc;
            if (wr_idx_reg == LAST_IDX)
            begin
                filled_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            enable_reg   <= 1'b0;
            filled_reg   <= 1'b0;
            wr_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            enable_reg   <= enable_next;
            filled_reg   <= filled_next;
            wr_idx_reg   <= wr_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        m_tdata_reg <= m_tdata_next;
    end

    // a beat is taken only from idle, so the next cycle is never ready
    `MTDR_ASSERT(a_accept_blocks, clk, rst_n, in_beat |=> !s_axis_tready)
    // bypass beats skip the multiply sequence
    `MTDR_ASSERT(a_bypass_done, clk, rst_n, (in_beat && !(enable_reg && filled_reg)) |=> (state_reg == ST_DONE))
    // the step counter never runs past the last sequencer step
    `MTDR_ASSERT(a_step_range, clk, rst_n, (state_reg == ST_RUN) |-> (step_reg <= ST_LAST))
    // reset leaves the sequencer idle with nothing to send
    `MTDR_ASSERT_RST(a_reset_idle, clk, !rst_n |=> ((state_reg == ST_IDLE) && !m_tvalid_reg))

endmodule

`default_nettype wire

@@ hw/rtl/mtdr_ring_ram.sv @@
// ----------------------------------------------------------------------------
// mtdr_ring_ram
// circular sample store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtdr_ring_ram (
    input  wire logic                          clk,
    input  wire logic                          we,
    input  wire logic [mtdr_pkg::ADDR_W-1:0]   waddr,
    input  wire logic [mtdr_pkg::SAMPLE_W-1:0] wdata,
    input  wire logic [mtdr_pkg::ADDR_W-1:0]   raddr,
    output logic      [mtdr_pkg::SAMPLE_W-1:0] rdata
);

    logic [mtdr_pkg::SAMPLE_W-1:0] mem [mtdr_pkg::RING_DEPTH];
    logic [mtdr_pkg::SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mtdr_mac.sv @@
// ----------------------------------------------------------------------------
// mtdr_mac
// shared multiplier with a registered product and an accumulator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtdr_mac (
    input  wire logic                               clk,
    input  wire mtdr_pkg::mac_ctl_t                 ctl,
    input  wire logic signed [mtdr_pkg::MUL_A_W-1:0] op_a,
    input  wire logic signed [mtdr_pkg::MUL_B_W-1:0] op_b,
    input  wire logic signed [mtdr_pkg::PROD_W-1:0]  init,
    output logic signed      [mtdr_pkg::PROD_W-1:0]  prod,
    output logic signed      [mtdr_pkg::PROD_W-1:0]  acc
);

    localparam logic signed [mtdr_pkg::PROD_W-1:0] HALF =
        mtdr_pkg::PROD_W'(64'sd1 <<< (2 * mtdr_pkg::FRAC_W - 1));

    logic signed [mtdr_pkg::PROD_W-1:0] prod_reg;
    logic signed [mtdr_pkg::PROD_W-1:0] prod_next;
    logic signed [mtdr_pkg::PROD_W-1:0] acc_reg;
    logic signed [mtdr_pkg::PROD_W-1:0] acc_next;

    always_comb
    begin
        prod_next = op_a * op_b;
        acc_next  = acc_reg;
        if (ctl.load)
        begin
            acc_next = init;
        end
        else if (ctl.add)
        begin
            acc_next = acc_reg + prod_reg;
        end
        else if (ctl.rnd)
        begin
            // add half of the final integer step to the low partial product, bring it to q16
            acc_next = (prod_reg + HALF) >>> mtdr_pkg::FRAC_W;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the five-tap delay echo: a directed table that also
// runs the first pass that fills the sample ring, then random sample streams.
// every output beat is compared against the table's value or, for untyped beats,
// against a bit-true echo predictor kept in the bench
`timescale 1ns / 1ps

module tb;

    typedef logic [mtdr_pkg::SAMPLE_W-1:0] sample_t;

    // directed table rows: a sample beat, an enable write, or the ring fill
    typedef enum logic [1:0] {ROW_BEAT, ROW_ENABLE, ROW_FILL} row_kind_t;

    // shapes of the random sample stream
    typedef enum logic [1:0] {SEG_WIDE, SEG_EDGE, SEG_QUIET, SEG_HOLD} seg_kind_t;

    typedef struct packed {
        row_kind_t kind;
        sample_t   data;
        logic      typed;
        sample_t   want;
    } stim_row_t;

    localparam int CYCLE_LIMIT      = 3000000;
    localparam int RESET_CYCLES     = 10;
    localparam int TAIL_CYCLES      = 40;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS      = 10;

    // random part: six phases, enable setting per phase (bit i = phase i)
    localparam int         NUM_RANDOM = 1500;
    localparam int         PHASE_LEN  = 250;
    localparam logic [5:0] PHASE_FX   = 6'b101101;
    localparam int         HOLD_AT    = 600;
    localparam int         DRAIN_AT   = 900;

    // echo arithmetic: dry gain 1.0, tap gains in q0.16, output scale 1/4.95
    localparam longint DRY_GAIN   = 65536;
    localparam int     ECHO_LAG  [mtdr_pkg::NUM_TAPS] = '{1600, 1792, 1952, 2176, 2304};
    localparam int     ECHO_GAIN [mtdr_pkg::NUM_TAPS] = '{54395, 53084, 51773, 50463, 49152};
    localparam longint POST_SCALE = 13240;
    localparam longint OUT_MAX    = (longint'(1) <<< (mtdr_pkg::SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN    = -OUT_MAX - 1;

    // fill layout: slots 0 and 1 of the first echo pass see only full-scale
    // positive taps, slots 706 and 707 only full-scale negative taps
    localparam int POS_RUN_FIRST = 1792;
    localparam int POS_RUN_LAST  = 2497;
    localparam int NEG_RUN_FIRST = 2498;
    localparam int NEG_RUN_LAST  = 3204;
    localparam int NEG_SAT_SLOT  = 706;

    localparam int DIR_ROWS_N = 22;
    localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
        // bypass straight out of reset, field extremes and bit patterns
        '{ROW_BEAT,   16'h0000, 1'b1, 16'h0000},
        '{ROW_BEAT,   16'h7fff, 1'b1, 16'h7fff},
        '{ROW_BEAT,   16'h8000, 1'b1, 16'h8000},
        '{ROW_BEAT,   16'hffff, 1'b1, 16'hffff},
        '{ROW_BEAT,   16'h0001, 1'b1, 16'h0001},
        '{ROW_BEAT,   16'haaaa, 1'b1, 16'haaaa},
        // first pass of the ring: stored but passed through
        '{ROW_ENABLE, 16'h0001, 1'b0, 16'h0000},
        '{ROW_BEAT,   16'h8000, 1'b1, 16'h8000},
        '{ROW_BEAT,   16'h7fff, 1'b1, 16'h7fff},
        '{ROW_BEAT,   16'h5555, 1'b1, 16'h5555},
        '{ROW_BEAT,   16'hffff, 1'b1, 16'hffff},
        // disabled in the middle of the first pass: nothing stored
        '{ROW_ENABLE, 16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT,   16'h1234, 1'b1, 16'h1234},
        '{ROW_ENABLE, 16'h0001, 1'b0, 16'h0000},
        // rest of the first pass up to the wrap
        '{ROW_FILL,   16'h0000, 1'b0, 16'h0000},
        // first echo beats: all taps full scale, sum clips high
        '{ROW_BEAT,   16'h7fff, 1'b1, 16'h7fff},
        '{ROW_BEAT,   16'h7fff, 1'b1, 16'h7fff},
        // disabled with a full ring: plain bypass
        '{ROW_ENABLE, 16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT,   16'h4321, 1'b1, 16'h4321},
        '{ROW_ENABLE, 16'h0001, 1'b0, 16'h0000},
        '{ROW_BEAT,   16'h0000, 1'b0, 16'h0000},
        '{ROW_BEAT,   16'h8000, 1'b0, 16'h0000}
    };

    // dut ports, all inputs known from time zero
    logic    clk           = 1'b0;
    logic    rst_n         = 1'b0;
    logic    enable_we     = 1'b0;
    logic    enable_wdata  = 1'b0;
    logic    s_axis_tvalid = 1'b0;
    logic    s_axis_tready;
    sample_t s_axis_tdata  = '0;  // [15:0] sample_in
    logic    m_axis_tvalid;
    logic    m_axis_tready = 1'b0;
    sample_t m_axis_tdata;        // [15:0] sample_out

    // echo predictor state, mirrors the block from reset
    logic signed [mtdr_pkg::SAMPLE_W-1:0] echo_ring [mtdr_pkg::RING_DEPTH];
    logic [mtdr_pkg::ADDR_W-1:0]          echo_wr_ptr    = '0;
    logic                                 echo_ring_full = 1'b0;
    logic                                 echo_on        = 1'b0;

    // expected output samples, oldest first
    sample_t sample_out_pending [$];

    int        fault_count   = 0;
    int        cycle_count   = 0;
    logic      calm          = 1'b0;  // no random gaps on either side while set
    logic      sink_hold_req = 1'b0;
    logic      offering      = 1'b0;  // shadow of s_axis_tvalid as last driven
    seg_kind_t seg_kind      = SEG_WIDE;
    int        seg_left      = 0;
    sample_t   seg_level     = '0;

    multi_tap_delay_reverb i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable_we     (enable_we),
        .enable_wdata  (enable_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one sample through the echo: stores it when enabled, mixes in the five
    // taps once the ring has wrapped, rounds half up and clips to the field
    function automatic sample_t predict_echo(input sample_t raw);
        logic [mtdr_pkg::ADDR_W-1:0] slot;
        logic [mtdr_pkg::ADDR_W-1:0] tap_slot;
        longint                      acc;
        longint                      mixed;
        sample_t                     result;
        result = raw;
        if (echo_on)
        begin
            slot = echo_wr_ptr;
            echo_ring[slot] = raw;
            if (echo_ring_full)
            begin
                acc = longint'($signed(raw)) * DRY_GAIN;
                for (int k = 0; k < mtdr_pkg::NUM_TAPS; k++)
                begin
                    tap_slot = slot - mtdr_pkg::ADDR_W'(ECHO_LAG[k]);
                    acc += longint'(echo_ring[tap_slot]) * longint'(ECHO_GAIN[k]);
                end
                // q.32 product, round half toward plus infinity
                mixed = (acc * POST_SCALE + (longint'(1) <<< 31)) >>> 32;
                if (mixed > OUT_MAX)
                    result = sample_t'(OUT_MAX);
                else if (mixed < OUT_MIN)
                    result = sample_t'(OUT_MIN);
                else
                    result = sample_t'(mixed);
            end
            echo_wr_ptr = echo_wr_ptr + 1'b1;
            if (echo_wr_ptr == '0)
                echo_ring_full = 1'b1;
        end
        return result;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 31);
        if (calm || roll < 16)
            return 0;
        if (roll < 30)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // first-pass content laid out for the clipping checks of the first echo pass
    function automatic sample_t fill_sample(input logic [mtdr_pkg::ADDR_W-1:0] slot);
        if (slot >= POS_RUN_FIRST && slot <= POS_RUN_LAST)
            return 16'h7fff;
        if (slot >= NEG_RUN_FIRST && slot <= NEG_RUN_LAST)
            return 16'h8000;
        return sample_t'($urandom);
    endfunction

    // random samples in runs of one shape: full range, extremes, quiet, or held
    function automatic sample_t next_sample();
        sample_t s;
        int      pick;
        // the slots that read the negative full-scale run get full scale too
        if (echo_on && echo_ring_full
                && (echo_wr_ptr == mtdr_pkg::ADDR_W'(NEG_SAT_SLOT)
                || echo_wr_ptr == mtdr_pkg::ADDR_W'(NEG_SAT_SLOT + 1)))
            return 16'h8000;
        if (seg_left == 0)
        begin
            seg_kind = seg_kind_t'($urandom_range(0, 3));
            seg_left = (seg_kind == SEG_HOLD) ? $urandom_range(100, 800)
                                              : $urandom_range(16, 200);
            pick = $urandom_range(0, 2);
            seg_level = (pick == 0) ? 16'h7fff : (pick == 1) ? 16'h8000
                                                              : sample_t'($urandom);
        end
        seg_left--;
        case (seg_kind)
            SEG_WIDE:
                s = sample_t'($urandom);
            SEG_EDGE:
            begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0:       s = 16'h7fff;
                    1:       s = 16'h8000;
                    2:       s = 16'h0000;
                    3:       s = 16'hffff;
                    default: s = sample_t'($urandom);
                endcase
            end
            SEG_QUIET:
                s = sample_t'(int'($urandom_range(0, 512)) - 256);
            default:
                s = seg_level;
        endcase
        return s;
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // offer one beat, then record what should come out for it
    task automatic send_sample(input sample_t data, input logic typed, input sample_t want);
        int      gap;
        sample_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            if (offering)
                s_axis_tvalid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        // predictor always steps so its state follows the block
        predicted = predict_echo(data);
        sample_out_pending.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait for every outstanding output beat
    task automatic wait_drained();
        if (offering)
            s_axis_tvalid <= 1'b0;
        offering = 1'b0;
        while (sample_out_pending.size() != 0)
            @(posedge clk);
    endtask

    // enable register write, only with the block idle
    task automatic write_enable(input logic value);
        wait_drained();
        enable_we    <= 1'b1;
        enable_wdata <= value;
        @(posedge clk);
        enable_we <= 1'b0;
        echo_on = value;
    endtask

    // output side: checks each accepted beat, stalls at random, and holds
    // off for a long stretch on request so the block backs up
    initial
    begin : sink
        int      sink_wait;
        sample_t want;
        sink_wait = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sample_out_pending.size() == 0)
                    note_fault($sformatf("unexpected sample_out %h with nothing pending",
                                         m_axis_tdata));
                else
                begin
                    want = sample_out_pending.pop_front();
                    if (m_axis_tdata !== want)
                        note_fault($sformatf("sample_out mismatch: expected %h got %h",
                                             want, m_axis_tdata));
                end
            end
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                sink_wait = SINK_HOLD_CYCLES;
            end
            if (sink_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_wait--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                sink_wait = pick_gap();
            end
        end
    end

    // hard stop if the run hangs
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL multi_tap_delay_reverb");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;
        int        phase;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIR_ROWS_N; r++)
        begin
            row = DIR_ROWS[r];
            case (row.kind)
                ROW_BEAT:
                    send_sample(row.data, row.typed, row.want);
                ROW_ENABLE:
                    write_enable(row.data[0]);
                default:
                    while (!echo_ring_full)
                        send_sample(fill_sample(echo_wr_ptr), 1'b0, '0);
            endcase
        end

        // random part, enable rewritten at each phase boundary
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                phase = n / PHASE_LEN;
                write_enable(PHASE_FX[phase]);
                calm = (phase == 3);
            end
            // long output stall with the input kept busy
            if (n == HOLD_AT)
            begin
                calm = 1'b1;
                sink_hold_req = 1'b1;
            end
            // input pauses until the output side has caught up
            if (n == DRAIN_AT || $urandom_range(0, 199) == 0)
                wait_drained();
            send_sample(next_sample(), 1'b0, '0);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && sample_out_pending.size() == 0)
            $display("PASS multi_tap_delay_reverb");
        else
            $display("FAIL multi_tap_delay_reverb");
        $finish;
    end

endmodule
